FILE: design/crs_pkg.sv
package crs_pkg;

  localparam int FIELD_W        = 16;
  localparam int SOL_W          = 48;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_RPAIRS     = 3;
  localparam int NUM_PAIRS      = 6;
  localparam int NUM_COMBOS     = 4;
  localparam int NUM_LANES      = 3;
  localparam int NUM_CELLS      = SOL_W;

  typedef enum logic [1:0] {
    ST_UNIQUE = 2'd0,
    ST_INCONS = 2'd1,
    ST_UNDER  = 2'd2
  } status_e;

  typedef struct packed {
    status_e                status;
    logic [1:0]             coef_rank;
    logic [1:0]             aug_rank;
    logic [NUM_LANES-1:0]   neg;
    logic [NUM_LANES-1:0]   over;
  } side_t;

  // row pairs for 2x2 minors
  localparam int RP0 [NUM_RPAIRS] = '{0, 0, 1};
  localparam int RP1 [NUM_RPAIRS] = '{1, 2, 2};
  // column pairs (a < b) over all four columns
  localparam int PC0 [NUM_PAIRS] = '{0, 0, 0, 1, 1, 2};
  localparam int PC1 [NUM_PAIRS] = '{1, 2, 3, 2, 3, 3};
  // sorted column triples: 012, 013, 023, 123
  localparam int CC0 [NUM_COMBOS] = '{0, 0, 0, 1};
  localparam int CC1 [NUM_COMBOS] = '{1, 1, 2, 2};
  localparam int CC2 [NUM_COMBOS] = '{2, 3, 3, 3};
  // column pair index of (c1,c2), (c0,c2), (c0,c1) for each triple
  localparam int K12 [NUM_COMBOS] = '{3, 4, 5, 5};
  localparam int K02 [NUM_COMBOS] = '{1, 2, 2, 4};
  localparam int K01 [NUM_COMBOS] = '{0, 0, 1, 3};
  // numerators: x = det(123), y = -det(023), z = det(013)
  localparam int LANE_SRC [NUM_LANES] = '{3, 2, 1};
  localparam logic LANE_FLIP [NUM_LANES] = '{1'b0, 1'b1, 1'b0};

endpackage

FILE: design/crs_front.sv
module crs_front #(
  parameter int CW   = crs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC = crs_pkg::FRAC_BITS_DEF
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               valid_i,
  output logic                                               hold_o,
  input  logic [11:0][crs_pkg::FIELD_W-1:0]                  mat_i,
  input  logic                                               hold_i,
  output logic                                               valid_o,
  output crs_pkg::side_t                                     side_o,
  output logic [3*CW:0]                                      den_o,
  output logic [crs_pkg::NUM_LANES-1:0][3*CW:0]              rem_o,
  output logic [crs_pkg::NUM_LANES-1:0][crs_pkg::SOL_W-1:0]  nq_o
);

  localparam int P_W   = 2 * CW;
  localparam int M_W   = 2 * CW + 1;
  localparam int T_W   = 3 * CW + 1;
  localparam int S_W   = 3 * CW + 3;
  localparam int DET_W = 3 * CW + 2;
  localparam int MAG_W = 3 * CW + 1;
  localparam int N_W   = MAG_W + crs_pkg::SOL_W;

  typedef logic signed [CW-1:0]    coef_t;
  typedef logic signed [P_W-1:0]   prod_t;
  typedef logic signed [M_W-1:0]   minor_t;
  typedef logic signed [T_W-1:0]   term_t;
  typedef logic signed [DET_W-1:0] det_t;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic hold1, hold2, hold3, hold4, hold5, hold6;

  assign hold6  = v6_q & hold_i;
  assign hold5  = v5_q & hold6;
  assign hold4  = v4_q & hold5;
  assign hold3  = v3_q & hold4;
  assign hold2  = v2_q & hold3;
  assign hold1  = v1_q & hold2;
  assign hold_o = hold1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (!hold1) v1_q <= valid_i;
      if (!hold2) v2_q <= v1_q;
      if (!hold3) v3_q <= v2_q;
      if (!hold4) v4_q <= v3_q;
      if (!hold5) v5_q <= v4_q;
      if (!hold6) v6_q <= v5_q;
    end
  end

  // stage 1: take the low bits of each field
  coef_t m1_q [3][4];

  always_ff @(posedge clk_i) begin
    if (!hold1) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          m1_q[r][c] <= mat_i[r*4+c][CW-1:0];
        end
      end
    end
  end

  // stage 2: products for every 2x2 minor
  prod_t p1_q [crs_pkg::NUM_RPAIRS][crs_pkg::NUM_PAIRS];
  prod_t p2_q [crs_pkg::NUM_RPAIRS][crs_pkg::NUM_PAIRS];
  coef_t a2_q [4];
  logic  nzc2_q, nza2_q;
  logic  nzc_d, nza_d;

  always_comb begin
    nzc_d = 1'b0;
    nza_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (m1_q[r][c] != '0) begin
          nza_d = 1'b1;
          if (c < 3) nzc_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold2) begin
      for (int rp = 0; rp < crs_pkg::NUM_RPAIRS; rp++) begin
        for (int k = 0; k < crs_pkg::NUM_PAIRS; k++) begin
          p1_q[rp][k] <= P_W'(m1_q[crs_pkg::RP0[rp]][crs_pkg::PC0[k]])
                       * P_W'(m1_q[crs_pkg::RP1[rp]][crs_pkg::PC1[k]]);
          p2_q[rp][k] <= P_W'(m1_q[crs_pkg::RP1[rp]][crs_pkg::PC0[k]])
                       * P_W'(m1_q[crs_pkg::RP0[rp]][crs_pkg::PC1[k]]);
        end
      end
      for (int c = 0; c < 4; c++) a2_q[c] <= m1_q[0][c];
      nzc2_q <= nzc_d;
      nza2_q <= nza_d;
    end
  end

  // stage 3: 2x2 minors
  minor_t d2_q [crs_pkg::NUM_RPAIRS][crs_pkg::NUM_PAIRS];
  coef_t  a3_q [4];
  logic   nzc3_q, nza3_q;

  always_ff @(posedge clk_i) begin
    if (!hold3) begin
      for (int rp = 0; rp < crs_pkg::NUM_RPAIRS; rp++) begin
        for (int k = 0; k < crs_pkg::NUM_PAIRS; k++) begin
          d2_q[rp][k] <= M_W'(p1_q[rp][k]) - M_W'(p2_q[rp][k]);
        end
      end
      for (int c = 0; c < 4; c++) a3_q[c] <= a2_q[c];
      nzc3_q <= nzc2_q;
      nza3_q <= nza2_q;
    end
  end

  // stage 4: cofactor terms along row 0, and the rank-2 tests
  term_t t_q [crs_pkg::NUM_COMBOS][3];
  logic  r2c4_q, r2a4_q, nzc4_q, nza4_q;
  logic  r2c_d, r2a_d;

  always_comb begin
    r2c_d = 1'b0;
    r2a_d = 1'b0;
    for (int rp = 0; rp < crs_pkg::NUM_RPAIRS; rp++) begin
      for (int k = 0; k < crs_pkg::NUM_PAIRS; k++) begin
        if (d2_q[rp][k] != '0) begin
          r2a_d = 1'b1;
          if (crs_pkg::PC1[k] != 3) r2c_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold4) begin
      for (int cb = 0; cb < crs_pkg::NUM_COMBOS; cb++) begin
        t_q[cb][0] <= T_W'(a3_q[crs_pkg::CC0[cb]]) * T_W'(d2_q[2][crs_pkg::K12[cb]]);
        t_q[cb][1] <= T_W'(a3_q[crs_pkg::CC1[cb]]) * T_W'(d2_q[2][crs_pkg::K02[cb]]);
        t_q[cb][2] <= T_W'(a3_q[crs_pkg::CC2[cb]]) * T_W'(d2_q[2][crs_pkg::K01[cb]]);
      end
      r2c4_q <= r2c_d;
      r2a4_q <= r2a_d;
      nzc4_q <= nzc3_q;
      nza4_q <= nza3_q;
    end
  end

  // stage 5: 3x3 determinants
  det_t                s5_q [crs_pkg::NUM_COMBOS];
  det_t                s5_d [crs_pkg::NUM_COMBOS];
  logic signed [S_W-1:0] sum_w [crs_pkg::NUM_COMBOS];
  logic                r2c5_q, r2a5_q, nzc5_q, nza5_q;

  always_comb begin
    for (int cb = 0; cb < crs_pkg::NUM_COMBOS; cb++) begin
      sum_w[cb] = S_W'(t_q[cb][0]) - S_W'(t_q[cb][1]) + S_W'(t_q[cb][2]);
      s5_d[cb]  = sum_w[cb][DET_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold5) begin
      for (int cb = 0; cb < crs_pkg::NUM_COMBOS; cb++) s5_q[cb] <= s5_d[cb];
      r2c5_q <= r2c4_q;
      r2a5_q <= r2a4_q;
      nzc5_q <= nzc4_q;
      nza5_q <= nza4_q;
    end
  end

  // stage 6: ranks, magnitudes and the start of the division
  crs_pkg::side_t side_d;
  logic [MAG_W-1:0] den_d;
  logic [MAG_W-1:0] num_abs [crs_pkg::NUM_LANES];
  logic [N_W-1:0]   nfull   [crs_pkg::NUM_LANES];
  logic [crs_pkg::NUM_LANES-1:0][MAG_W-1:0]         rem_d;
  logic [crs_pkg::NUM_LANES-1:0][crs_pkg::SOL_W-1:0] nq_d;
  det_t den_neg, num_sel, num_neg;
  logic r3c, r3a;

  always_comb begin
    r3c = (s5_q[0] != '0);
    r3a = (s5_q[0] != '0) || (s5_q[1] != '0) || (s5_q[2] != '0) || (s5_q[3] != '0);

    side_d = '0;
    priority if (r3c)    side_d.coef_rank = 2'd3;
    else if (r2c5_q)     side_d.coef_rank = 2'd2;
    else if (nzc5_q)     side_d.coef_rank = 2'd1;
    else                 side_d.coef_rank = 2'd0;
    priority if (r3a)    side_d.aug_rank = 2'd3;
    else if (r2a5_q)     side_d.aug_rank = 2'd2;
    else if (nza5_q)     side_d.aug_rank = 2'd1;
    else                 side_d.aug_rank = 2'd0;

    priority if (side_d.coef_rank != side_d.aug_rank) side_d.status = crs_pkg::ST_INCONS;
    else if (side_d.coef_rank != 2'd3)                side_d.status = crs_pkg::ST_UNDER;
    else                                              side_d.status = crs_pkg::ST_UNIQUE;

    den_neg = -s5_q[0];
    den_d   = s5_q[0][DET_W-1] ? den_neg[MAG_W-1:0] : s5_q[0][MAG_W-1:0];

    num_sel = '0;
    num_neg = '0;
    for (int l = 0; l < crs_pkg::NUM_LANES; l++) begin
      num_sel = s5_q[crs_pkg::LANE_SRC[l]];
      num_neg = -num_sel;
      num_abs[l] = num_sel[DET_W-1] ? num_neg[MAG_W-1:0] : num_sel[MAG_W-1:0];
      side_d.neg[l] = num_sel[DET_W-1] ^ s5_q[0][DET_W-1] ^ crs_pkg::LANE_FLIP[l];
      // numerator scaled by 2^FRAC, split into the starting remainder and the bits to bring down
      nfull[l] = {num_abs[l], {crs_pkg::SOL_W{1'b0}}} >> (crs_pkg::SOL_W - FRAC);
      rem_d[l] = nfull[l][N_W-1:crs_pkg::SOL_W];
      nq_d[l]  = nfull[l][crs_pkg::SOL_W-1:0];
      side_d.over[l] = (rem_d[l] >= den_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold6) begin
      side_o <= side_d;
      den_o  <= den_d;
      rem_o  <= rem_d;
      nq_o   <= nq_d;
    end
  end

  assign valid_o = v6_q;

endmodule

FILE: design/crs_div_cell.sv
module crs_div_cell #(
  parameter int MAG_W = 3 * crs_pkg::COEF_WIDTH_DEF + 1
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               valid_i,
  input  crs_pkg::side_t                                     side_i,
  input  logic [MAG_W-1:0]                                   den_i,
  input  logic [crs_pkg::NUM_LANES-1:0][MAG_W-1:0]           rem_i,
  input  logic [crs_pkg::NUM_LANES-1:0][crs_pkg::SOL_W-1:0]  nq_i,
  input  logic                                               hold_i,
  output logic                                               hold_o,
  output logic                                               valid_o,
  output crs_pkg::side_t                                     side_o,
  output logic [MAG_W-1:0]                                   den_o,
  output logic [crs_pkg::NUM_LANES-1:0][MAG_W-1:0]           rem_o,
  output logic [crs_pkg::NUM_LANES-1:0][crs_pkg::SOL_W-1:0]  nq_o
);

  logic v_q;
  logic [MAG_W:0] rem_ext [crs_pkg::NUM_LANES];
  logic [MAG_W:0] diff    [crs_pkg::NUM_LANES];
  logic [crs_pkg::NUM_LANES-1:0] ge;
  logic [crs_pkg::NUM_LANES-1:0][MAG_W-1:0]          rem_d;
  logic [crs_pkg::NUM_LANES-1:0][crs_pkg::SOL_W-1:0] nq_d;

  assign hold_o  = v_q & hold_i;
  assign valid_o = v_q;

  // one restoring step per lane: bring down the next bit, subtract if it fits
  always_comb begin
    for (int l = 0; l < crs_pkg::NUM_LANES; l++) begin
      rem_ext[l] = {rem_i[l], nq_i[l][crs_pkg::SOL_W-1]};
      diff[l]    = rem_ext[l] - {1'b0, den_i};
      ge[l]      = (rem_ext[l] >= {1'b0, den_i});
      rem_d[l]   = ge[l] ? diff[l][MAG_W-1:0] : rem_ext[l][MAG_W-1:0];
      nq_d[l]    = {nq_i[l][crs_pkg::SOL_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!hold_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold_o) begin
      side_o <= side_i;
      den_o  <= den_i;
      rem_o  <= rem_d;
      nq_o   <= nq_d;
    end
  end

endmodule

FILE: design/cramer_solver_3x3_core.sv
// 3x3 linear system solver by Cramer's rule.
// Input channel: in_valid_i / in_stall_o carry one augmented matrix [A | b] per
// beat, twelve signed fields m11_i..m34_i; the low COEF_WIDTH bits of each are used.
// Output channel: out_valid_o / out_stall_i carry one result per beat: status,
// sol_x/y/z as signed fixed point with FRAC_BITS fraction bits (truncated toward
// zero, saturated to 48 bits), both ranks and the saturated flag.
// The pipeline is the front stages of minors and ranks, a chain of 48 divider
// cells with one quotient bit per cell (all three quotients step together), and
// one output register. Throughput is one beat per cycle while no stall holds the
// chain; every stage holds one item and hands it on each cycle unless held.
// Reset clears every stage's valid flag; the pipeline comes up empty.
// When the receiver stalls, the output holds its beat and stages behind it
// stop only once they are full, so empty stages keep taking input until
// the chain backs up to in_stall_o.
module cramer_solver_3x3_core #(
  parameter int COEF_WIDTH = crs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = crs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m11_i,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m12_i,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m13_i,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m14_i,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m21_i,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m22_i,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m23_i,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m24_i,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m31_i,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m32_i,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m33_i,
  input  logic signed [crs_pkg::FIELD_W-1:0]  m34_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [crs_pkg::SOL_W-1:0]    sol_x_o,
  output logic signed [crs_pkg::SOL_W-1:0]    sol_y_o,
  output logic signed [crs_pkg::SOL_W-1:0]    sol_z_o,
  output logic [1:0]                          coef_rank_o,
  output logic [1:0]                          aug_rank_o,
  output logic                                saturated_o
);

  localparam int MAG_W = 3 * COEF_WIDTH + 1;
  localparam int NC    = crs_pkg::NUM_CELLS;
  localparam int NL    = crs_pkg::NUM_LANES;
  localparam int SW    = crs_pkg::SOL_W;

  logic [11:0][crs_pkg::FIELD_W-1:0] mat;

  assign mat[0]  = m11_i;
  assign mat[1]  = m12_i;
  assign mat[2]  = m13_i;
  assign mat[3]  = m14_i;
  assign mat[4]  = m21_i;
  assign mat[5]  = m22_i;
  assign mat[6]  = m23_i;
  assign mat[7]  = m24_i;
  assign mat[8]  = m31_i;
  assign mat[9]  = m32_i;
  assign mat[10] = m33_i;
  assign mat[11] = m34_i;

  logic                            v_c    [NC+1];
  logic                            hold_c [NC+1];
  crs_pkg::side_t                  side_c [NC+1];
  logic [MAG_W-1:0]                den_c  [NC+1];
  logic [NL-1:0][MAG_W-1:0]        rem_c  [NC+1];
  logic [NL-1:0][SW-1:0]           nq_c   [NC+1];

  crs_front #(
    .CW   (COEF_WIDTH),
    .FRAC (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .hold_o  (in_stall_o),
    .mat_i   (mat),
    .hold_i  (hold_c[0]),
    .valid_o (v_c[0]),
    .side_o  (side_c[0]),
    .den_o   (den_c[0]),
    .rem_o   (rem_c[0]),
    .nq_o    (nq_c[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    crs_div_cell #(
      .MAG_W (MAG_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_c[i]),
      .side_i  (side_c[i]),
      .den_i   (den_c[i]),
      .rem_i   (rem_c[i]),
      .nq_i    (nq_c[i]),
      .hold_i  (hold_c[i+1]),
      .hold_o  (hold_c[i]),
      .valid_o (v_c[i+1]),
      .side_o  (side_c[i+1]),
      .den_o   (den_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .nq_o    (nq_c[i+1])
    );
  end

  // output register
  logic out_v_q;
  logic out_hold;

  assign out_hold   = out_v_q & out_stall_i;
  assign hold_c[NC] = out_hold;

  crs_pkg::side_t   fin;
  logic [SW-1:0]    lim   [NL];
  logic [SW-1:0]    mag   [NL];
  logic [SW-1:0]    res_d [NL];
  logic [NL-1:0]    sat_l;
  logic             sat_d;

  always_comb begin
    fin = side_c[NC];
    for (int l = 0; l < NL; l++) begin
      // limit is 2^47 for negative results, 2^47-1 otherwise
      lim[l]   = {fin.neg[l], {(SW-1){~fin.neg[l]}}};
      sat_l[l] = fin.over[l] || (nq_c[NC][l] > lim[l]);
      mag[l]   = sat_l[l] ? lim[l] : nq_c[NC][l];
      res_d[l] = fin.neg[l] ? (SW'(0) - mag[l]) : mag[l];
    end
    sat_d = |sat_l;
    if (fin.status != crs_pkg::ST_UNIQUE) begin
      for (int l = 0; l < NL; l++) res_d[l] = '0;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_hold) begin
      out_v_q <= v_c[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_hold) begin
      status_o    <= fin.status;
      sol_x_o     <= res_d[0];
      sol_y_o     <= res_d[1];
      sol_z_o     <= res_d[2];
      coef_rank_o <= fin.coef_rank;
      aug_rank_o  <= fin.aug_rank;
      saturated_o <= sat_d;
    end
  end

  assign out_valid_o = out_v_q;

endmodule
